// ===== src/mmcr_pkg.sv =====
// mmcr_pkg: shared types and constants of the min-max column rescaler.
// Holds the beat structs, the register indexes, the FSM states and the divider status.
// No dependencies.
`default_nettype none

package mmcr_pkg;

    localparam int DATA_W    = 32;
    localparam int ROW_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     is_last;
    } t_sample_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] scaled_value;
        logic [ROW_W-1:0]         row_index;
        logic                     last_of_run;
        logic                     constant_column;
        logic                     dropped;
    } t_result_beat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_FETCH,
        ST_MUL,
        ST_DIVST,
        ST_DWAIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/mmcr_buf.sv =====
// mmcr_buf: sample buffer, one write port and one read port, registered read data.
// Depends on mmcr_pkg for the data width.
`default_nettype none

module mmcr_buf #(
    parameter int DEPTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire logic [mmcr_pkg::DATA_W-1:0]  i_wr_data,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic      [mmcr_pkg::DATA_W-1:0]  o_rd_data
);
    import mmcr_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/mmcr_div.sv =====
// mmcr_div: iterative unsigned 64 / 32 divider, two quotient bits per cycle.
// The caller guarantees dividend[63:32] < divisor, so the quotient fits 32 bits.
// Depends on mmcr_pkg for widths and the status struct.
`default_nettype none

module mmcr_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [2*mmcr_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [mmcr_pkg::DATA_W-1:0]   i_divisor,
    output logic      [mmcr_pkg::DATA_W-1:0]   o_quotient,
    output mmcr_pkg::t_div_status              o_status
);
    import mmcr_pkg::*;

    localparam int BITS_PER_CYCLE = 2;
    localparam int STEPS          = DATA_W / BITS_PER_CYCLE;
    localparam int CNT_W          = $clog2(STEPS);

    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] n_rem;
    logic [DATA_W-1:0] n_lo;

    // restoring steps: shift in the next dividend bit, subtract when it fits
    always_comb begin
        logic [DATA_W:0] t;
        n_rem = r_rem;
        n_lo  = r_lo;
        for (int s = 0; s < BITS_PER_CYCLE; s++) begin
            t = {n_rem, n_lo[DATA_W-1]};
            if (t >= {1'b0, r_div}) begin
                t    = t - {1'b0, r_div};
                n_lo = {n_lo[DATA_W-2:0], 1'b1};
            end else begin
                n_lo = {n_lo[DATA_W-2:0], 1'b0};
            end
            n_rem = t[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_status <= '0;
            r_cnt    <= '0;
        end else if (i_start) begin
            o_status.busy <= 1'b1;
            o_status.done <= 1'b0;
            r_cnt         <= CNT_W'(STEPS - 1);
        end else if (o_status.busy) begin
            if (r_cnt == '0) begin
                o_status.busy <= 1'b0;
                o_status.done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end else begin
            o_status.done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*DATA_W-1:DATA_W];
            r_lo  <= i_dividend[DATA_W-1:0];
            r_div <= i_divisor;
        end else if (o_status.busy) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
        end
    end

    assign o_quotient = r_lo;

endmodule

`default_nettype wire

// ===== src/min_max_column_rescaler_top.sv =====
// min_max_column_rescaler_top: min-max normalization of one column of Q16.16 samples.
// Load: one sample per cycle while busy is low; the sample marked last starts the drain.
// Drain: one result per cycle for a constant column; otherwise each result steps through the
// fetch, multiply and divider-start states, then waits for the divider (2 quotient bits a cycle).
// The drain opens with a setup state after the last sample; results never stall.
// Synchronous active-low reset clears control state; buffer contents stay undefined.
`default_nettype none

module min_max_column_rescaler_top #(
    parameter int DEPTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // sample channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire mmcr_pkg::t_sample_beat            i_sample,
    // result channel
    output logic                                   o_res_strobe,
    output mmcr_pkg::t_result_beat                 o_result,
    // configuration channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [mmcr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mmcr_pkg::DATA_W-1:0]       i_cfg_data
);
    import mmcr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    // configuration registers
    logic signed [DATA_W-1:0] r_lower;
    logic signed [DATA_W-1:0] r_upper;

    // column state
    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_fill;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] r_max;
    logic                     r_ovf;

    // drain datapath
    logic [AW-1:0]            r_k;
    logic                     r_flat;
    logic                     r_neg;
    logic [DATA_W-1:0]        r_range;
    logic [DATA_W-1:0]        r_span;
    logic [DATA_W-1:0]        r_d;
    logic [2*DATA_W-1:0]      r_prod;

    // control decode
    logic                     accept;
    logic                     full;
    logic                     k_last;
    logic                     emit;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic                     div_start;
    logic [DATA_W-1:0]        rd_data;
    logic [DATA_W-1:0]        quotient;
    t_div_status              div_st;
    logic [DATA_W:0]          bound_diff;
    logic [DATA_W:0]          bound_mag;
    logic [DATA_W-1:0]        scaled;

    assign busy        = (r_state != ST_LOAD);
    assign accept      = start && !busy;
    assign full        = (r_fill == CW'(DEPTH));
    assign wr_en       = accept && !full;
    assign o_cfg_ready = 1'b1;
    assign k_last      = ((CW'(r_k) + CW'(1)) == r_fill);

    // buffer and divider
    mmcr_buf #(
        .DEPTH(DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_sample.sample_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mmcr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_quotient (quotient),
        .o_status   (div_st)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && i_sample.is_last) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_FETCH;
            ST_FETCH: begin
                if (!r_flat) begin
                    n_state = ST_MUL;
                end else if (k_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_MUL:   n_state = ST_DIVST;
            ST_DIVST: n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (div_st.done) begin
                    n_state = k_last ? ST_LOAD : ST_FETCH;
                end
            end
            default:  n_state = ST_LOAD;
        endcase
    end

    // state outputs: emit a beat, issue the next buffer read, kick the divider
    always_comb begin
        emit      = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            ST_FETCH: emit      = r_flat;
            ST_DIVST: div_start = 1'b1;
            ST_DWAIT: emit      = div_st.done;
            default: begin
                emit      = 1'b0;
                div_start = 1'b0;
            end
        endcase
        rd_en   = (r_state == ST_SETUP) || (emit && !k_last);
        rd_addr = (r_state == ST_SETUP) ? '0 : r_k + AW'(1);
    end

    // mapping range, taken once per column
    assign bound_diff = {r_upper[DATA_W-1], r_upper} - {r_lower[DATA_W-1], r_lower};
    assign bound_mag  = bound_diff[DATA_W] ? -bound_diff : bound_diff;

    // flat column passes the stored sample; otherwise offset the quotient from lower
    always_comb begin
        if (r_flat) begin
            scaled = rd_data;
        end else if (r_neg) begin
            scaled = $unsigned(r_lower) - quotient;
        end else begin
            scaled = $unsigned(r_lower) + quotient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_lower      <= '0;
            r_upper      <= DATA_W'(65536);
            r_fill       <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_ovf        <= 1'b0;
            r_k          <= '0;
            o_res_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            o_res_strobe <= emit;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LOWER_BOUND) begin
                    r_lower <= i_cfg_data;
                end else if (i_cfg_index == CFG_UPPER_BOUND) begin
                    r_upper <= i_cfg_data;
                end
            end

            // load: store the sample and track extremes, flag overflow when full
            if (accept) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_fill <= r_fill + CW'(1);
                    if (r_fill == '0) begin
                        r_min <= i_sample.sample_value;
                        r_max <= i_sample.sample_value;
                    end else begin
                        if (i_sample.sample_value < r_min) begin
                            r_min <= i_sample.sample_value;
                        end
                        if (i_sample.sample_value > r_max) begin
                            r_max <= i_sample.sample_value;
                        end
                    end
                end
            end

            if (r_state == ST_SETUP) begin
                r_k <= '0;
            end else if (emit) begin
                r_k <= r_k + AW'(1);
                // column done: drop the running state
                if (k_last) begin
                    r_fill <= '0;
                    r_min  <= '0;
                    r_max  <= '0;
                    r_ovf  <= 1'b0;
                end
            end
        end
    end

    // drain datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SETUP) begin
            r_flat  <= (r_max == r_min);
            r_span  <= $unsigned(r_max) - $unsigned(r_min);
            r_neg   <= bound_diff[DATA_W];
            r_range <= bound_mag[DATA_W-1:0];
        end
        if (r_state == ST_FETCH) begin
            r_d <= rd_data - $unsigned(r_min);
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_d * r_range;
        end
        if (emit) begin
            o_result.scaled_value    <= scaled;
            o_result.row_index       <= ROW_W'(r_k);
            o_result.last_of_run     <= k_last;
            o_result.constant_column <= r_flat;
            o_result.dropped         <= r_ovf;
        end
    end

    // the divider runs only while the sequencer waits on it
    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.busy |-> (r_state == ST_DWAIT))
        else $error("divider busy outside the wait state");

    // every result beat comes out of a drain
    a_strobe_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> ($past(r_state) != ST_LOAD))
        else $error("result beat without a drain");

    // the fill count never passes the buffer depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count beyond buffer depth");

    // a drain always has at least one stored sample
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SETUP) |-> (r_fill != '0))
        else $error("drain of an empty column");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for min_max_column_rescaler_top.
// Drives columns of Q16.16 samples under several bound settings, predicts every rescaled
// beat in SystemVerilog and compares field by field. Depends on mmcr_pkg and the top.
`timescale 1ns / 100ps

module testbench;
    import mmcr_pkg::*;

    localparam int DEPTH         = 64;
    localparam int CYCLE_LIMIT   = 400000;
    // idle time waited after each drain, before the next part of the test
    localparam int DRAIN_SETTLE  = 40;
    localparam int PHASE_ITEMS   = 45;

    // indexes outside the register map: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = CFG_IDX_W'(3);

    // value patterns of a random column
    typedef enum int {
        VAL_FULL,
        VAL_NARROW,
        VAL_FLAT,
        VAL_EXTREME
    } t_value_mode;

    // directed row: n_typed > 0 means the column's results are typed in below,
    // otherwise the predictor supplies them
    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              last;
        logic [1:0]        n_typed;
        logic [DATA_W-1:0] v0;
        logic [DATA_W-1:0] v1;
        logic [DATA_W-1:0] v2;
        logic              flat;
    } t_directed_row;

    // Rows run under the reset bounds 0 .. 1.0
    localparam int N_DIRECTED = 17;
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        // single sample columns are flat: passed through unchanged
        '{32'h7FFF_FFFF, 1'b1, 2'd1, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1},
        '{32'h8000_0000, 1'b1, 2'd1, 32'h8000_0000, 32'h0, 32'h0, 1'b1},
        // full-range span: min maps to lower, max to upper
        '{32'h8000_0000, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 2'd2, 32'h0, 32'h0001_0000, 32'h0, 1'b0},
        // repeated value: flat column of three
        '{32'h0000_0005, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'h0000_0005, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'h0000_0005, 1'b1, 2'd3, 32'h5, 32'h5, 32'h5, 1'b1},
        // even ramp lands on 0, 0.5, 1.0
        '{32'h0000_000A, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'h0000_0014, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'h0000_001E, 1'b1, 2'd3, 32'h0, 32'h0000_8000, 32'h0001_0000, 1'b0},
        // max arrives first
        '{32'h0001_0000, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'hFFFF_0000, 1'b1, 2'd2, 32'h0001_0000, 32'h0, 32'h0, 1'b0},
        // mixed signs and extremes, predicted; last a single zero sample, typed as flat
        '{32'hFFFF_FFFF, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'h8000_0000, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'h0000_0003, 1'b1, 2'd0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'h0000_0000, 1'b1, 2'd1, 32'h0, 32'h0, 32'h0, 1'b1}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_sample_beat          i_sample;
    logic                  o_res_strobe;
    t_result_beat          o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [DATA_W-1:0]     i_cfg_data;

    min_max_column_rescaler_top #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sample     (i_sample),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Shadow of the block: bounds and the column being loaded
    logic signed [DATA_W-1:0] bound_lo;
    logic signed [DATA_W-1:0] bound_hi;
    logic signed [DATA_W-1:0] column_buf [DEPTH];
    logic [6:0]               column_fill;
    logic signed [DATA_W-1:0] column_min;
    logic signed [DATA_W-1:0] column_max;
    logic                     column_overflow;

    // Rescaled beats still owed by the block, oldest first
    t_result_beat scaled_q [$];

    int  error_count;
    int  cycle_count;
    bit  quiet_column;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Map one sample onto [lower, upper]; the product fits 64 unsigned bits
    // because both the offset and the range magnitude stay below 2^32.
    function automatic logic [DATA_W-1:0] rescale_sample(input logic signed [DATA_W-1:0] x);
        logic [63:0] offset;
        logic [63:0] span;
        logic [63:0] magnitude;
        logic [63:0] quotient;
        longint      range;
        offset    = 64'(longint'(x) - longint'(column_min));
        span      = 64'(longint'(column_max) - longint'(column_min));
        range     = longint'(bound_hi) - longint'(bound_lo);
        magnitude = (range < 0) ? 64'(-range) : 64'(range);
        quotient  = (offset * magnitude) / span;
        if (range < 0)
            return DATA_W'(longint'(bound_lo) - longint'(quotient));
        return DATA_W'(longint'(bound_lo) + longint'(quotient));
    endfunction

    // Fold one accepted sample into the shadow column; on the last mark emit the
    // rescaled column into scaled_q (when asked) and clear the column.
    function automatic void absorb_sample(input t_sample_beat b, input bit emit);
        int           n;
        logic         flat;
        t_result_beat r;
        if (column_fill < DEPTH) begin
            column_buf[column_fill[$clog2(DEPTH)-1:0]] = b.sample_value;
            if (column_fill == 0) begin
                column_min = b.sample_value;
                column_max = b.sample_value;
            end else begin
                if (b.sample_value < column_min) column_min = b.sample_value;
                if (b.sample_value > column_max) column_max = b.sample_value;
            end
            column_fill = column_fill + 1;
        end else begin
            column_overflow = 1'b1;
        end
        if (!b.is_last)
            return;
        n    = column_fill;
        flat = (column_max == column_min);
        if (emit) begin
            for (int k = 0; k < n; k++) begin
                r.scaled_value    = flat ? column_buf[k] : rescale_sample(column_buf[k]);
                r.row_index       = ROW_W'(k);
                r.last_of_run     = (k == n - 1);
                r.constant_column = flat;
                r.dropped         = column_overflow;
                scaled_q.push_back(r);
            end
        end
        column_fill     = '0;
        column_overflow = 1'b0;
        column_min      = '0;
        column_max      = '0;
    endfunction

    // Mostly back to back or short gaps, now and then a long one
    function automatic int sender_gap();
        int r;
        if (quiet_column) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Present one sample beat and hold it until the block takes it.
    // Drop start only when a gap follows, so start never toggles within a step.
    task automatic send_sample(input t_sample_beat b);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_sample <= b;
        do @(posedge i_clk); while (busy);
    endtask

    // One register beat; valid stays up so back-to-back writes need no toggle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LOWER_BOUND)
            bound_lo = data;
        else if (idx == CFG_UPPER_BOUND)
            bound_hi = data;
    endtask

    task automatic set_bounds(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        write_reg(CFG_UNUSED_2, $urandom);
        write_reg(CFG_LOWER_BOUND, lo);
        write_reg(CFG_UPPER_BOUND, hi);
        write_reg(CFG_UNUSED_3, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every owed beat arrived and the block went idle, then settle
    task automatic wait_drained();
        while (scaled_q.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_sample(input t_value_mode mode,
                                                      input logic [DATA_W-1:0] base);
        case (mode)
            VAL_NARROW: return base + DATA_W'($urandom_range(0, 15));
            VAL_FLAT:   return base;
            VAL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0;
                    default: return $urandom;
                endcase
            end
            default:    return $urandom;
        endcase
    endfunction

    // Well-formed column of random content; length 0 picks one at random,
    // mostly short, some long, a few that overrun the buffer
    task automatic send_column(input int len_req, inout int sent);
        int           len;
        int           r;
        t_value_mode  mode;
        logic [DATA_W-1:0] base;
        t_sample_beat b;
        len = len_req;
        if (len == 0) begin
            r = $urandom_range(0, 99);
            if (r < 60)      len = $urandom_range(1, 6);
            else if (r < 85) len = $urandom_range(7, 20);
            else if (r < 97) len = $urandom_range(21, DEPTH);
            else             len = $urandom_range(DEPTH + 1, DEPTH + 4);
        end
        mode         = t_value_mode'($urandom_range(0, 3));
        base         = $urandom;
        quiet_column = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            b.sample_value = pick_sample(mode, base);
            b.is_last      = (i == len - 1);
            send_sample(b);
            absorb_sample(b, 1'b1);
        end
        sent += len;
    endtask

    // Compare each strobed beat with the oldest owed one
    always @(posedge i_clk) begin : result_check
        t_result_beat want;
        if (i_rst_n && o_res_strobe) begin
            if (scaled_q.size() == 0) begin
                $error("unexpected result beat: scaled_value %0d row %0d",
                       o_result.scaled_value, o_result.row_index);
                error_count++;
            end else begin
                want = scaled_q.pop_front();
                if (o_result.scaled_value !== want.scaled_value) begin
                    $error("scaled_value: expected %0d, got %0d",
                           want.scaled_value, o_result.scaled_value);
                    error_count++;
                end
                if (o_result.row_index !== want.row_index) begin
                    $error("row_index: expected %0d, got %0d",
                           want.row_index, o_result.row_index);
                    error_count++;
                end
                if (o_result.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, o_result.last_of_run);
                    error_count++;
                end
                if (o_result.constant_column !== want.constant_column) begin
                    $error("constant_column: expected %0b, got %0b",
                           want.constant_column, o_result.constant_column);
                    error_count++;
                end
                if (o_result.dropped !== want.dropped) begin
                    $error("dropped: expected %0b, got %0b",
                           want.dropped, o_result.dropped);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [DATA_W-1:0] lo_set [6];
        logic [DATA_W-1:0] hi_set [6];
        t_sample_beat      b;
        t_result_beat      r;
        int                sent;
        int                n;

        error_count  = 0;
        cycle_count  = 0;
        quiet_column = 1'b0;

        // drive every input to a known value and hold reset
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_sample    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;

        // shadow state after reset
        bound_lo        = 32'sh0000_0000;
        bound_hi        = 32'sh0001_0000;
        column_fill     = '0;
        column_min      = '0;
        column_max      = '0;
        column_overflow = 1'b0;
        foreach (column_buf[i]) column_buf[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset bounds
        for (int row = 0; row < N_DIRECTED; row++) begin
            b.sample_value = DIRECTED[row].sample;
            b.is_last      = DIRECTED[row].last;
            quiet_column   = ($urandom_range(0, 1) == 0);
            send_sample(b);
            n = DIRECTED[row].n_typed;
            absorb_sample(b, n == 0);
            for (int k = 0; k < n; k++) begin
                r.scaled_value    = (k == 0) ? DIRECTED[row].v0 :
                                    (k == 1) ? DIRECTED[row].v1 : DIRECTED[row].v2;
                r.row_index       = ROW_W'(k);
                r.last_of_run     = (k == n - 1);
                r.constant_column = DIRECTED[row].flat;
                r.dropped         = 1'b0;
                scaled_q.push_back(r);
            end
        end
        start <= 1'b0;
        wait_drained();

        // Random part: one phase per bound setting, extremes and inversion first
        lo_set[0] = 32'h8000_0000; hi_set[0] = 32'h7FFF_FFFF;
        lo_set[1] = 32'h7FFF_FFFF; hi_set[1] = 32'h8000_0000;
        lo_set[2] = 32'h0001_0000; hi_set[2] = 32'h0001_0000;
        lo_set[3] = 32'hFFFF_0000; hi_set[3] = 32'h0001_0000;
        lo_set[4] = $urandom;      hi_set[4] = $urandom;
        lo_set[5] = 32'h0000_0000; hi_set[5] = 32'h0001_0000;

        for (int phase = 0; phase < 6; phase++) begin
            set_bounds(lo_set[phase], hi_set[phase]);
            sent = 0;
            // force an overrun column with the last mark on a discarded sample,
            // and one column that fills the buffer exactly
            if (phase == 1) send_column(DEPTH + 2, sent);
            if (phase == 2) send_column(DEPTH, sent);
            while (sent < PHASE_ITEMS)
                send_column(0, sent);
            start <= 1'b0;
            wait_drained();
        end

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
